// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int SIZE_W              = 5;
   localparam int MAX_SIZE            = (2 ** SIZE_W) - 1;
   localparam int KEY_W               = 64;
   localparam int KEY_BYTES           = KEY_W / 8;
   localparam int KM_W                = 31;
   localparam int SLOT_W              = 4;
   localparam int STATUS_W            = 2;
   localparam int SUM_W               = 11;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(16);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } lpht_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_NO_TABLE  = 2'd3
   } lpht_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_DIV,
      S_READ,
      S_CHECK,
      S_DONE
   } lpht_state_type;

   typedef struct packed {
      logic load;
      logic no_table;
      logic sum;
      logic div;
      logic read;
      logic check;
   } lpht_cmd_type;

   typedef struct packed {
      logic size_zero;
      logic div_last;
      logic probe_hit;
      logic probe_last;
   } lpht_flag_type;

endpackage
`default_nettype wire

// ===== rtl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: hash, bit-serial remainder, read and compare of each probe.
// ----------------------------------------------------------------------------
module lpht_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  lpht_pkg::lpht_flag_type flag,
   output lpht_pkg::lpht_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import lpht_pkg::*;

   lpht_state_type state_ff;
   lpht_state_type state_in;
   logic           open_w;

   assign open_w = (state_ff == S_IDLE) || (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE, S_DONE: begin
            if (start) begin
               state_in = flag.size_zero ? S_DONE : S_SUM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SUM: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            state_in = flag.div_last ? S_READ : S_DIV;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = (flag.probe_hit || flag.probe_last) ? S_DONE : S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.load     = open_w && start;
      cmd.no_table = open_w && start && flag.size_zero;
      cmd.sum      = (state_ff == S_SUM);
      cmd.div      = (state_ff == S_DIV);
      cmd.read     = (state_ff == S_READ);
      cmd.check    = (state_ff == S_CHECK);
      busy         = !open_w;
      rsp_valid    = (state_ff == S_DONE);
   end

endmodule
`default_nettype wire

// ===== rtl/lpht_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_dpath
// Size register, key trim and byte sum, remainder unit, slot store, results.
// ----------------------------------------------------------------------------
module lpht_dpath #(
   parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire  [lpht_pkg::SIZE_W-1:0]        csr_wdata,
   input  wire                                req_operation,
   input  wire  [lpht_pkg::KEY_W-1:0]         req_key,
   input  wire  [lpht_pkg::KM_W-1:0]          req_km_value,
   input  lpht_pkg::lpht_cmd_type             cmd,
   output lpht_pkg::lpht_flag_type            flag,
   output logic [lpht_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [lpht_pkg::KM_W-1:0]          rsp_found_km
);
   import lpht_pkg::*;

   localparam int STORE_DEPTH = (TABLE_DEPTH < MAX_SIZE) ? TABLE_DEPTH : MAX_SIZE;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(SUM_W);

   function automatic logic [KEY_W-1:0] key_trim(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] trimmed;
      logic             live;
      trimmed = '0;
      live    = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         live = live && (key[8*i +: 8] != 8'd0);
         if (live) begin
            trimmed[8*i +: 8] = key[8*i +: 8];
         end
      end
      return trimmed;
   endfunction

   function automatic logic [SUM_W-1:0] byte_sum(input logic [KEY_W-1:0] key);
      logic [SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         acc = acc + SUM_W'(key[8*i +: 8]);
      end
      return acc;
   endfunction

   logic [SIZE_W-1:0]      table_size_ff;
   logic                   op_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [KM_W-1:0]        km_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SIZE_W-1:0]      rem_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [SIZE_W-1:0]      n_ff;
   logic [STORE_DEPTH-1:0] used_ff;
   logic                   rd_used_ff;
   logic [KEY_W-1:0]       rd_key_ff;
   logic [KM_W-1:0]        rd_km_ff;
   lpht_status_type        status_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [KM_W-1:0]        found_km_ff;

   logic [KEY_W-1:0]       key_mem [STORE_DEPTH];
   logic [KM_W-1:0]        km_mem  [STORE_DEPTH];

   logic [SIZE_W-1:0]      size_eff;
   logic [SIZE_W:0]        rem_shift;
   logic                   rem_ge;
   logic [SIZE_W-1:0]      rem_in;
   logic [SIZE_W-1:0]      idx_inc;
   logic [IDX_W-1:0]       idx_in;
   logic                   is_lookup;
   logic                   hit;
   logic                   last;

   assign size_eff  = (table_size_ff > SIZE_W'(STORE_DEPTH)) ? SIZE_W'(STORE_DEPTH)
                                                             : table_size_ff;
   assign rem_shift = {rem_ff, sum_ff[cnt_ff]};
   assign rem_ge    = rem_shift >= {1'b0, size_ff};
   assign rem_in    = rem_ge ? SIZE_W'(rem_shift - {1'b0, size_ff}) : rem_shift[SIZE_W-1:0];
   assign idx_inc   = SIZE_W'(idx_ff) + SIZE_W'(1);
   assign idx_in    = (idx_inc == size_ff) ? '0 : idx_inc[IDX_W-1:0];
   assign is_lookup = (op_ff == OP_LOOKUP);
   assign hit       = is_lookup ? (rd_used_ff && (rd_key_ff == key_ff)) : !rd_used_ff;
   assign last      = (n_ff == (size_ff - SIZE_W'(1)));

   assign flag.size_zero  = (table_size_ff == '0);
   assign flag.div_last   = (cnt_ff == '0);
   assign flag.probe_hit  = hit;
   assign flag.probe_last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
         used_ff       <= '0;
      end else begin
         if (csr_we) begin
            table_size_ff <= csr_wdata;
         end
         if (cmd.check && hit && !is_lookup) begin
            used_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         key_ff  <= key_trim(req_key);
         km_ff   <= req_km_value;
         size_ff <= size_eff;
      end
      if (cmd.sum) begin
         sum_ff <= byte_sum(key_ff);
         rem_ff <= '0;
         cnt_ff <= CNT_W'(SUM_W - 1);
      end
      if (cmd.div) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            idx_ff <= rem_in[IDX_W-1:0];
            n_ff   <= '0;
         end
      end
      if (cmd.read) begin
         rd_used_ff <= used_ff[idx_ff];
      end
      if (cmd.check && !hit && !last) begin
         idx_ff <= idx_in;
         n_ff   <= n_ff + SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_key_ff <= key_mem[idx_ff];
         rd_km_ff  <= km_mem[idx_ff];
      end
      if (cmd.check && hit && !is_lookup) begin
         key_mem[idx_ff] <= key_ff;
         km_mem[idx_ff]  <= km_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.no_table) begin
         status_ff   <= STATUS_NO_TABLE;
         slot_ff     <= '0;
         found_km_ff <= '0;
      end else if (cmd.check && hit) begin
         status_ff   <= STATUS_OK;
         slot_ff     <= SLOT_W'(idx_ff);
         found_km_ff <= is_lookup ? rd_km_ff : '0;
      end else if (cmd.check && last) begin
         status_ff   <= is_lookup ? STATUS_NOT_FOUND : STATUS_FULL;
         slot_ff     <= '0;
         found_km_ff <= '0;
      end
   end

   assign rsp_status   = status_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_found_km = found_km_ff;

endmodule
`default_nettype wire

// ===== rtl/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing: insert and lookup of
// 8-byte keys carrying a 31-bit mileage value.
// ----------------------------------------------------------------------------
// An item shows its result on rsp_valid after the byte sum, the bit-serial
// remainder of that sum by the table size (capped at the store depth), and
// for each probe a registered slot read and a key compare; the next item is
// accepted only once the previous one is done. With a table size of zero the
// result follows in the next cycle. busy drops during the cycle that shows a
// result, so a new item can start there. Each result is on the rsp_ ports for
// exactly one cycle and the receiver cannot stall it. Write the table size
// through csr_we and csr_wdata only while no item is in flight.
module linear_probe_hash_table_unit #(
   parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire  [lpht_pkg::SIZE_W-1:0]    csr_wdata,
   input  wire                            start,
   output logic                           busy,
   input  wire                            req_operation,
   input  wire  [lpht_pkg::KEY_W-1:0]     req_key,
   input  wire  [lpht_pkg::KM_W-1:0]      req_km_value,
   output logic                           rsp_valid,
   output logic [lpht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [lpht_pkg::KM_W-1:0]      rsp_found_km
);
   import lpht_pkg::*;

   lpht_cmd_type  cmd;
   lpht_flag_type flag;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .flag      (flag),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lpht_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_km_value  (req_km_value),
      .cmd           (cmd),
      .flag          (flag),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_found_km  (rsp_found_km)
   );

endmodule
`default_nettype wire

// ===== rtl/lpht_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table unit, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            start,
   input wire                            busy,
   input wire                            rsp_valid,
   input wire [lpht_pkg::STATUS_W-1:0]   rsp_status,
   input wire [lpht_pkg::SLOT_W-1:0]     rsp_slot,
   input wire [lpht_pkg::KM_W-1:0]       rsp_found_km
);
   import lpht_pkg::*;

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_slot == '0) && (rsp_found_km == '0))
      else $error("failed item carries nonzero slot or mileage");

   a_result_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy high while a result is shown");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item neither in work nor answered");

   a_quiet_stays_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && !rsp_valid && !start |=> !busy && !rsp_valid)
      else $error("activity without an accepted item");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_slot     (rsp_slot),
   .rsp_found_km (rsp_found_km)
);
`default_nettype wire

// ===== sim/tb_linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_unit
// Self-checking bench for the linear probing hash table unit. A directed
// table of inserts, lookups and table size writes is walked first, then
// random phases run at several table sizes. Every accepted item is run
// through a bit-true model of the table; its outcome, or a typed row's own,
// is matched against each strobed result in order.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_unit;
   import lpht_pkg::*;

   localparam int DEPTH       = TABLE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 60;
   localparam int PHASES      = 10;

   typedef struct packed {
      lpht_status_type   status;
      logic [SLOT_W-1:0] slot;
      logic [KM_W-1:0]   found_km;
   } table_outcome_type;

   typedef enum bit { ROW_ITEM, ROW_SIZE } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [SIZE_W-1:0] size;
      lpht_op_type       op;
      logic [KEY_W-1:0]  key;
      logic [KM_W-1:0]   km;
      bit                typed;
      lpht_status_type   status;
      logic [SLOT_W-1:0] slot;
      logic [KM_W-1:0]   found_km;
   } directed_row_type;

   localparam logic [KM_W-1:0]  KM_MAX   = {KM_W{1'b1}};
   localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

   directed_row_type directed_rows [22] = '{
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h41, 31'd0, 1'b1, STATUS_NOT_FOUND, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_INSERT, 64'h41, KM_MAX, 1'b1, STATUS_OK, 4'd1, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h41, 31'd0, 1'b1, STATUS_OK, 4'd1, KM_MAX},
      '{ROW_ITEM, 5'd0,  OP_INSERT, KEY_ONES, 31'd0, 1'b1, STATUS_OK, 4'd8, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, KEY_ONES, KM_MAX, 1'b1, STATUS_OK, 4'd8, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_INSERT, 64'h0, 31'h12345, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_INSERT, 64'h51, 31'h55, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_INSERT, 64'hA5A5_0000_00FF_0041, 31'h3, 1'b0,
        STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h0000_1234_5600_0041, 31'h7, 1'b0,
        STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h4100, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h51, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h5A41, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_SIZE, 5'd0,  OP_INSERT, 64'h0, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_INSERT, 64'h41, 31'h9, 1'b1, STATUS_NO_TABLE, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h41, 31'd0, 1'b1, STATUS_NO_TABLE, 4'd0, 31'd0},
      '{ROW_SIZE, 5'd31, OP_INSERT, 64'h0, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, KEY_ONES, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_SIZE, 5'd1,  OP_INSERT, 64'h0, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_INSERT, 64'h42, 31'h1, 1'b1, STATUS_FULL, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h41, 31'd0, 1'b1, STATUS_NOT_FOUND, 4'd0, 31'd0},
      '{ROW_ITEM, 5'd0,  OP_LOOKUP, 64'h0, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0},
      '{ROW_SIZE, 5'd16, OP_INSERT, 64'h0, 31'd0, 1'b0, STATUS_OK, 4'd0, 31'd0}
   };

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                csr_we        = 1'b0;
   logic [SIZE_W-1:0]   csr_wdata     = '0;
   logic                start         = 1'b0;
   logic                req_operation = 1'b0;
   logic [KEY_W-1:0]    req_key       = '0;
   logic [KM_W-1:0]     req_km_value  = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [KM_W-1:0]     rsp_found_km;

   int unsigned         model_size = TABLE_SIZE_RESET;
   bit                  model_used [DEPTH];
   logic [KEY_W-1:0]    model_key  [DEPTH];
   logic [KM_W-1:0]     model_km   [DEPTH];

   table_outcome_type   pending_outcomes [$];
   logic [KEY_W-1:0]    inserted_keys    [$];
   int                  error_count = 0;
   int                  cycle_count = 0;

   linear_probe_hash_table_unit dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_km_value  (req_km_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_found_km  (rsp_found_km)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] t;
      bit               ended;
      t     = '0;
      ended = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (k[8*i +: 8] == 8'h00) ended = 1'b1;
         if (!ended) t[8*i +: 8] = k[8*i +: 8];
      end
      return t;
   endfunction

   function automatic table_outcome_type hash_table_access(input lpht_op_type op,
                                                           input logic [KEY_W-1:0] raw_key,
                                                           input logic [KM_W-1:0] km);
      table_outcome_type r;
      logic [KEY_W-1:0]  k;
      int unsigned       size;
      int unsigned       sum;
      int unsigned       idx;
      r.status   = STATUS_OK;
      r.slot     = '0;
      r.found_km = '0;
      size = (model_size > DEPTH) ? DEPTH : model_size;
      if (size == 0) begin
         r.status = STATUS_NO_TABLE;
         return r;
      end
      k   = trim_key(raw_key);
      sum = 0;
      for (int i = 0; i < KEY_BYTES; i++) sum += k[8*i +: 8];
      idx = sum % size;
      for (int n = 0; n < size; n++) begin
         if (op == OP_INSERT) begin
            if (!model_used[idx]) begin
               model_used[idx] = 1'b1;
               model_key[idx]  = k;
               model_km[idx]   = km;
               r.slot          = SLOT_W'(idx);
               return r;
            end
         end else if (model_used[idx] && model_key[idx] == k) begin
            r.slot     = SLOT_W'(idx);
            r.found_km = model_km[idx];
            return r;
         end
         idx = (idx + 1 == size) ? 0 : idx + 1;
      end
      r.status = (op == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      int               len;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) return k;
      len = $urandom_range(0, KEY_BYTES);
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (i < len) k[8*i +: 8] = 8'($urandom_range(1, 255));
         else if (i == len || $urandom_range(0, 1) == 0) k[8*i +: 8] = 8'h00;
      end
      return k;
   endfunction

   task automatic issue_request(input lpht_op_type op, input logic [KEY_W-1:0] key,
                                input logic [KM_W-1:0] km, input bit typed,
                                input table_outcome_type typed_outcome);
      int                gap;
      table_outcome_type predicted;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_km_value  <= km;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = hash_table_access(op, key, km);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic drain_outcomes();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_table_size(input int unsigned size);
      drain_outcomes();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= SIZE_W'(size);
      @(posedge clock);
      csr_we     <= 1'b0;
      model_size = size;
   endtask

   always @(posedge clock) begin
      table_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: status %0d slot %0d km %0h",
                        rsp_status, rsp_slot, rsp_found_km);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_slot !== want.slot ||
                rsp_found_km !== want.found_km) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected status %0d slot %0d km %0h, got %0d %0d %0h",
                           want.status, want.slot, want.found_km,
                           rsp_status, rsp_slot, rsp_found_km);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      table_outcome_type typed_outcome;
      lpht_op_type       op;
      logic [KEY_W-1:0]  key;
      logic [KM_W-1:0]   km;
      bit                ended;
      int unsigned       phase_sizes [PHASES];
      int                count;

      phase_sizes = '{4, 9, 0, 16, 1, 31, 0, 16, 12, 17};
      phase_sizes[8] = $urandom_range(2, 15);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SIZE) begin
            write_table_size(directed_rows[r].size);
         end else begin
            typed_outcome.status   = directed_rows[r].status;
            typed_outcome.slot     = directed_rows[r].slot;
            typed_outcome.found_km = directed_rows[r].found_km;
            issue_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].km,
                          directed_rows[r].typed, typed_outcome);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_table_size(phase_sizes[p]);
         count = (phase_sizes[p] == 0) ? 15 : 70;
         for (int i = 0; i < count; i++) begin
            if (p == 3 && i == 30) drain_outcomes();
            case ($urandom_range(0, 7))
               0:       km = '0;
               1:       km = KM_MAX;
               default: km = KM_W'($urandom);
            endcase
            if (inserted_keys.size() == 0 || $urandom_range(0, 1) == 0) begin
               op = OP_INSERT;
               if (inserted_keys.size() != 0 && $urandom_range(0, 4) == 0)
                  key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
               else
                  key = random_key();
               inserted_keys.push_back(key);
            end else begin
               op = OP_LOOKUP;
               if ($urandom_range(0, 9) < 7) begin
                  key   = trim_key(inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
                  ended = 1'b0;
                  for (int b = 0; b < KEY_BYTES; b++) begin
                     if (key[8*b +: 8] == 8'h00) begin
                        if (ended && $urandom_range(0, 1) == 1) key[8*b +: 8] = 8'($urandom);
                        ended = 1'b1;
                     end
                  end
               end else begin
                  key = random_key();
               end
            end
            issue_request(op, key, km, 1'b0, '0);
         end
      end

      drain_outcomes();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
